// ===== src/hmbf_pkg.sv =====
// hmbf_pkg: constants, types and codes shared by the height map box filter
// used by the channel interfaces, the controller, the datapath and the top level
`timescale 1ns / 1ps

package hmbf_pkg;

  // sample and map geometry
  localparam int SampleBits = 16;
  localparam int MaxWidth   = 1024;
  localparam int MaxRows    = 1024;
  localparam int ColBits    = $clog2(MaxWidth);
  localparam int RowBits    = $clog2(MaxRows);
  localparam int OutColBits = 10;
  localparam int OutRowBits = 10;

  // configuration port
  localparam int CfgBits    = 11;
  localparam int CfgIdxBits = 4;
  localparam logic [CfgBits-1:0] MapDimReset = CfgBits'(513);

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_MAP_WIDTH  = 0,
    CFG_MAP_HEIGHT = 1
  } cfg_reg_e;

  // arithmetic widths
  localparam int ColSumBits = SampleBits + 2;
  localparam int SumBits    = SampleBits + 4;
  localparam int QuotBits   = SampleBits + 1;
  localparam int Shift3     = SumBits + 2;
  localparam int Shift9     = SumBits + 4;
  localparam int RecipBits  = SumBits + 1;
  localparam int ProdBits   = SumBits + RecipBits;

  // rounded-up reciprocals, exact for every numerator below 2**SumBits
  localparam logic [RecipBits-1:0] Recip3 =
    RecipBits'(((64'd1 << Shift3) + 64'd2) / 64'd3);
  localparam logic [RecipBits-1:0] Recip9 =
    RecipBits'(((64'd1 << Shift9) + 64'd8) / 64'd9);

  typedef enum logic [2:0] {
    DIV_BY_1,
    DIV_BY_2,
    DIV_BY_3,
    DIV_BY_4,
    DIV_BY_6,
    DIV_BY_9
  } div_mode_e;

  // result kinds, in emission order; also the bit index of the pending mask
  typedef enum logic [1:0] {
    RES_UP_LEFT = 2'd0,
    RES_UP      = 2'd1,
    RES_LEFT    = 2'd2,
    RES_HERE    = 2'd3
  } res_kind_e;

  localparam int NumRes = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_COLS,
    ST_TOTAL,
    ST_MUL,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic      accept;
    logic      fetch;
    logic      cols;
    logic      total;
    logic      mul;
    logic      emit;
    logic      last;
    res_kind_e sel;
  } hmbf_cmd_t;

  typedef struct packed {
    logic              in_valid;
    logic              out_free;
    logic [NumRes-1:0] res_mask;
  } hmbf_stat_t;

endpackage

// ===== src/hmbf_if.sv =====
// hmbf channel interfaces: sample input, filtered result output, register writes
// depends on hmbf_pkg
`timescale 1ns / 1ps

interface hmbf_in_if;
  import hmbf_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] height_in;
  modport source (output valid, output height_in, input ready);
  modport sink (input valid, input height_in, output ready);
endinterface

interface hmbf_out_if;
  import hmbf_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] height_out;
  logic        [OutColBits-1:0] out_col;
  logic        [OutRowBits-1:0] out_row;
  logic                         last_of_run;
  modport source (output valid, output height_out, output out_col, output out_row,
                  output last_of_run, input ready);
  modport sink (input valid, input height_out, input out_col, input out_row,
                input last_of_run, output ready);
endinterface

interface hmbf_cfg_if;
  import hmbf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CfgIdxBits-1:0] index;
  logic [CfgBits-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/hmbf_ctrl.sv =====
// hmbf_ctrl: sequencer for one sample transaction and the results it causes
// depends on hmbf_pkg
`timescale 1ns / 1ps

module hmbf_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  hmbf_pkg::hmbf_stat_t   stat_i,
  output logic                   in_ready_o,
  output hmbf_pkg::hmbf_cmd_t    cmd_o
);
  import hmbf_pkg::*;

  ctrl_state_e       state_q, state_d;
  logic [NumRes-1:0] pend_q, pend_d;
  logic [NumRes-1:0] sel_bit;
  logic [NumRes-1:0] pend_rest;
  res_kind_e         sel;

  // lowest pending result goes first
  always_comb begin
    if (pend_q[RES_UP_LEFT]) begin
      sel = RES_UP_LEFT;
    end else if (pend_q[RES_UP]) begin
      sel = RES_UP;
    end else if (pend_q[RES_LEFT]) begin
      sel = RES_LEFT;
    end else begin
      sel = RES_HERE;
    end
  end

  assign sel_bit   = NumRes'(1) << sel;
  assign pend_rest = pend_q & ~sel_bit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    pend_d     = pend_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.sel  = sel;
    cmd_o.last = (pend_rest == '0);
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (stat_i.in_valid) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        pend_d      = stat_i.res_mask;
        state_d     = (stat_i.res_mask == '0) ? ST_IDLE : ST_COLS;
      end
      ST_COLS: begin
        cmd_o.cols = 1'b1;
        state_d    = ST_TOTAL;
      end
      ST_TOTAL: begin
        cmd_o.total = 1'b1;
        state_d     = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          pend_d     = pend_rest;
          state_d    = (pend_rest == '0) ? ST_IDLE : ST_COLS;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_then_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> state_q == ST_FETCH)
    else $error("sample transaction not followed by line store fetch");

  a_last_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit && cmd_o.last |=> state_q == ST_IDLE && pend_q == '0)
    else $error("results still pending after last emit");

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> pend_q == '0)
    else $error("pending results left while idle");

  a_emit_selected_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (pend_q & sel_bit) != '0)
    else $error("emit of a result that was not pending");
`endif

endmodule

// ===== src/hmbf_datapath.sv =====
// hmbf_datapath: line stores, 3x3 window, counters, masked sum, constant divide
// and the output register; depends on hmbf_pkg
`timescale 1ns / 1ps

module hmbf_datapath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  hmbf_pkg::hmbf_cmd_t                    cmd_i,
  output hmbf_pkg::hmbf_stat_t                   stat_o,
  input  logic                                   in_valid_i,
  input  logic signed [hmbf_pkg::SampleBits-1:0] height_in_i,
  input  logic                                   cfg_valid_i,
  input  logic [hmbf_pkg::CfgIdxBits-1:0]        cfg_index_i,
  input  logic [hmbf_pkg::CfgBits-1:0]           cfg_data_i,
  input  logic                                   out_ready_i,
  output logic                                   out_valid_o,
  output logic signed [hmbf_pkg::SampleBits-1:0] height_out_o,
  output logic [hmbf_pkg::OutColBits-1:0]        out_col_o,
  output logic [hmbf_pkg::OutRowBits-1:0]        out_row_o,
  output logic                                   last_of_run_o
);
  import hmbf_pkg::*;

  // configuration and position counters
  logic [CfgBits-1:0] width_q, height_q;
  logic [ColBits-1:0] col_cnt_q;
  logic [RowBits-1:0] row_cnt_q;
  logic [ColBits:0]   w_eff;
  logic [RowBits:0]   h_eff;
  logic               last_col, last_row;
  logic               cfg_hit;

  // current item
  logic signed [SampleBits-1:0] samp_q;
  logic [ColBits-1:0]           col_q;
  logic [RowBits-1:0]           row_q;

  // line stores and window
  logic [SampleBits-1:0]        upper_mem [MaxWidth];
  logic [SampleBits-1:0]        middle_mem [MaxWidth];
  logic [SampleBits-1:0]        up_rd_q, mid_rd_q;
  logic signed [SampleBits-1:0] win_q [3][3];

  // arithmetic
  logic [2:0]                   row_en, col_en;
  logic [1:0]                   n_rows, n_cols;
  logic signed [ColSumBits-1:0] colsum_d [3];
  logic signed [ColSumBits-1:0] colsum_q [3];
  logic signed [SumBits-1:0]    total;
  logic [SumBits-1:0]           mag;
  logic [SumBits-1:0]           half;
  div_mode_e                    mode_d, mode_q;
  logic [SumBits-1:0]           num_q;
  logic                         neg_q;
  logic [SumBits-1:0]           pre_x;
  logic [RecipBits-1:0]         recip;
  logic [ProdBits-1:0]          prod_q;
  logic [QuotBits-1:0]          quo;
  logic [QuotBits-1:0]          val;
  logic [ColBits-1:0]           res_col;
  logic [RowBits-1:0]           res_row;
  logic                         out_valid_q;

  // effective map size: zero acts as one, oversize saturates
  always_comb begin
    if (width_q == '0) begin
      w_eff = (ColBits+1)'(1);
    end else if (int'(width_q) > MaxWidth) begin
      w_eff = (ColBits+1)'(MaxWidth);
    end else begin
      w_eff = (ColBits+1)'(width_q);
    end
    if (height_q == '0) begin
      h_eff = (RowBits+1)'(1);
    end else if (int'(height_q) > MaxRows) begin
      h_eff = (RowBits+1)'(MaxRows);
    end else begin
      h_eff = (RowBits+1)'(height_q);
    end
  end

  assign last_col = ((ColBits+1)'(col_q) == w_eff - (ColBits+1)'(1));
  assign last_row = ((RowBits+1)'(row_q) == h_eff - (RowBits+1)'(1));
  assign cfg_hit  = cfg_valid_i &&
                    (cfg_index_i == CFG_MAP_WIDTH || cfg_index_i == CFG_MAP_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= MapDimReset;
      height_q  <= MapDimReset;
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_MAP_WIDTH:  width_q  <= cfg_data_i;
          CFG_MAP_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
      end
      // a register write restarts the frame
      if (cfg_hit) begin
        col_cnt_q <= '0;
        row_cnt_q <= '0;
      end else if (cmd_i.fetch) begin
        if (last_col) begin
          col_cnt_q <= '0;
          row_cnt_q <= last_row ? '0 : row_q + RowBits'(1);
        end else begin
          col_cnt_q <= col_q + ColBits'(1);
        end
      end
    end
  end

  // item capture, line store read on accept, read-modify-write in the cycle after
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      samp_q   <= height_in_i;
      col_q    <= col_cnt_q;
      row_q    <= row_cnt_q;
      up_rd_q  <= upper_mem[col_cnt_q];
      mid_rd_q <= middle_mem[col_cnt_q];
    end
    if (cmd_i.fetch) begin
      upper_mem[col_q]  <= mid_rd_q;
      middle_mem[col_q] <= samp_q;
    end
  end

  // window rows are r-2, r-1, r; columns c-2, c-1, c
  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= win_q[i][2];
      end
      win_q[0][2] <= up_rd_q;
      win_q[1][2] <= mid_rd_q;
      win_q[2][2] <= samp_q;
    end
  end

  // neighbours that lie inside the map for the selected result
  always_comb begin
    if (cmd_i.sel == RES_UP_LEFT || cmd_i.sel == RES_UP) begin
      row_en = {1'b1, 1'b1, row_q >= RowBits'(2)};
    end else begin
      row_en = {1'b1, row_q >= RowBits'(1), 1'b0};
    end
    if (cmd_i.sel == RES_UP_LEFT || cmd_i.sel == RES_LEFT) begin
      col_en = {1'b1, 1'b1, col_q >= ColBits'(2)};
    end else begin
      col_en = {1'b1, col_q >= ColBits'(1), 1'b0};
    end
  end

  assign n_rows = 2'(row_en[0]) + 2'(row_en[1]) + 2'(row_en[2]);
  assign n_cols = 2'(col_en[0]) + 2'(col_en[1]) + 2'(col_en[2]);

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      colsum_d[j] = '0;
      for (int i = 0; i < 3; i++) begin
        if (row_en[i]) begin
          colsum_d[j] = colsum_d[j] + ColSumBits'(win_q[i][j]);
        end
      end
    end
  end

  always_comb begin
    total = '0;
    for (int j = 0; j < 3; j++) begin
      if (col_en[j]) begin
        total = total + SumBits'(colsum_q[j]);
      end
    end
  end

  assign mag = total[SumBits-1] ? SumBits'(-total) : SumBits'(total);

  always_comb begin
    case ({n_rows, n_cols}) inside
      4'b0110, 4'b1001: mode_d = DIV_BY_2;
      4'b0111, 4'b1101: mode_d = DIV_BY_3;
      4'b1010:          mode_d = DIV_BY_4;
      4'b1011, 4'b1110: mode_d = DIV_BY_6;
      4'b1111:          mode_d = DIV_BY_9;
      default:          mode_d = DIV_BY_1;
    endcase
    case (mode_d)
      DIV_BY_2, DIV_BY_3: half = SumBits'(1);
      DIV_BY_4:           half = SumBits'(2);
      DIV_BY_6:           half = SumBits'(3);
      DIV_BY_9:           half = SumBits'(4);
      default:            half = '0;
    endcase
  end

  // divide by 2, 4, 6 pre-shifts; 3, 6, 9 multiply by a rounded-up reciprocal
  always_comb begin
    case (mode_q)
      DIV_BY_2, DIV_BY_6: pre_x = num_q >> 1;
      DIV_BY_4:           pre_x = num_q >> 2;
      default:            pre_x = num_q;
    endcase
    case (mode_q)
      DIV_BY_3, DIV_BY_6: recip = Recip3;
      DIV_BY_9:           recip = Recip9;
      default:            recip = RecipBits'(1);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cols) begin
      colsum_q <= colsum_d;
    end
    if (cmd_i.total) begin
      num_q  <= mag + half;
      neg_q  <= total[SumBits-1];
      mode_q <= mode_d;
    end
    if (cmd_i.mul) begin
      prod_q <= ProdBits'(pre_x) * ProdBits'(recip);
    end
  end

  always_comb begin
    case (mode_q)
      DIV_BY_3, DIV_BY_6: quo = QuotBits'(prod_q >> Shift3);
      DIV_BY_9:           quo = QuotBits'(prod_q >> Shift9);
      default:            quo = QuotBits'(prod_q);
    endcase
    val = neg_q ? -quo : quo;
    res_col = (cmd_i.sel == RES_UP_LEFT || cmd_i.sel == RES_LEFT) ?
              col_q - ColBits'(1) : col_q;
    res_row = (cmd_i.sel == RES_UP_LEFT || cmd_i.sel == RES_UP) ?
              row_q - RowBits'(1) : row_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      height_out_o  <= SampleBits'(val);
      out_col_o     <= OutColBits'(res_col);
      out_row_o     <= OutRowBits'(res_row);
      last_of_run_o <= cmd_i.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stat_o.in_valid = in_valid_i;
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign stat_o.res_mask = {last_row && last_col,
                            last_row && (col_q >= ColBits'(1)),
                            (row_q >= RowBits'(1)) && last_col,
                            (row_q >= RowBits'(1)) && (col_q >= ColBits'(1))};

`ifndef SYNTHESIS
  a_col_in_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ColBits+1)'(col_cnt_q) < w_eff)
    else $error("column counter outside the map");

  a_row_in_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (RowBits+1)'(row_cnt_q) < h_eff)
    else $error("row counter outside the map");

  a_emit_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> out_valid_q)
    else $error("emitted result not held in output register");
`endif

endmodule

// ===== src/heightmap_box_filter_3x3_top.sv =====
// heightmap_box_filter_3x3_top: streaming 3x3 border-normalised mean filter
// depends on hmbf_pkg, hmbf_if, hmbf_ctrl and hmbf_datapath
//
//   port    direction  contents
//   in_i    sink       height_in, signed Q8.8, raster order
//   out_o   source     height_out, out_col, out_row, last_of_run
//   cfg_i   sink       index 0 map_width, index 1 map_height; always ready
//
// an item is accepted and gets a line store read-modify-write, then each result
// takes column sums, total and rounding, reciprocal multiply and output load;
// an item yields no result, one inside the map, up to four at the bottom right
// corner; the single shared sum and divide sequence takes one sample at a time
// reset needs no clearing pass; line stores and window are not reset
// a full output register stalls the sequence only at the output load step
`timescale 1ns / 1ps

module heightmap_box_filter_3x3_top (
  input logic        clk_i,
  input logic        rst_ni,
  hmbf_in_if.sink    in_i,
  hmbf_out_if.source out_o,
  hmbf_cfg_if.sink   cfg_i
);
  import hmbf_pkg::*;

  hmbf_cmd_t  cmd;
  hmbf_stat_t stat;
  logic       in_ready;

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  hmbf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stat_i     (stat),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  hmbf_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .in_valid_i    (in_i.valid),
    .height_in_i   (in_i.height_in),
    .cfg_valid_i   (cfg_i.valid),
    .cfg_index_i   (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .height_out_o  (out_o.height_out),
    .out_col_o     (out_o.out_col),
    .out_row_o     (out_o.out_row),
    .last_of_run_o (out_o.last_of_run)
  );

endmodule

// ===== dv/heightmap_box_filter_3x3_top_tb.sv =====
// heightmap_box_filter_3x3_top_tb: checks the 3x3 border-normalised mean filter against
// an in-bench model of line stores, window and counters; depends on hmbf_pkg, hmbf_if
// and heightmap_box_filter_3x3_top
`timescale 1ns / 1ps

module heightmap_box_filter_3x3_top_tb;
  import hmbf_pkg::*;

  localparam int          ClkPeriod     = 10;
  localparam int          ResetCycles   = 11;
  localparam int          SettleCycles  = 40;
  localparam int          RandomHeights = 150;
  localparam int unsigned CycleLimit    = 1_000_000;
  localparam int          PrintLimit    = 100;

  typedef struct packed {
    logic signed [SampleBits-1:0] height_out;
    logic        [OutColBits-1:0] out_col;
    logic        [OutRowBits-1:0] out_row;
    logic                         last_of_run;
  } filt_mean_t;

  typedef enum {
    READY_ALWAYS,
    READY_COIN,
    READY_ONE_IN_FOUR,
    READY_LONG_HOLD
  } sink_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  hmbf_in_if  in_if ();
  hmbf_out_if out_if ();
  hmbf_cfg_if cfg_if ();

  heightmap_box_filter_3x3_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // model state
  logic [CfgBits-1:0] map_width;
  logic [CfgBits-1:0] map_height;
  int                 upper_line [MaxWidth];
  int                 middle_line [MaxWidth];
  int                 win [3][3];
  int                 col_cnt;
  int                 row_cnt;

  logic signed [SampleBits-1:0] height_stream [$];
  filt_mean_t                   awaited_means [$];

  int          mismatch_count;
  int unsigned cycle_count;
  int          burst_left;
  int          gap_left;
  int unsigned stall_tick;
  sink_mode_e  stall_mode;

  function automatic int clamp_dim(int v, int top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  // mean over window rows r0..2 and columns c0..2, ties away from zero
  function automatic logic signed [SampleBits-1:0] window_mean(int r0, int c0);
    int sum;
    int n;
    int mag;
    int q;
    sum = 0;
    n = 0;
    for (int r = r0; r < 3; r++) begin
      for (int c = c0; c < 3; c++) begin
        sum += win[r][c];
        n++;
      end
    end
    mag = (sum < 0) ? -sum : sum;
    q = (mag + n / 2) / n;
    return SampleBits'((sum < 0) ? -q : q);
  endfunction

  task automatic queue_mean(input filt_mean_t m);
    awaited_means.insert(awaited_means.size(), m);
  endtask

  task automatic queue_height(input logic signed [SampleBits-1:0] h);
    height_stream.insert(height_stream.size(), h);
  endtask

  task automatic compute_window_means(input logic signed [SampleBits-1:0] sample);
    int w;
    int h;
    int c;
    int r;
    int rows_full;
    int rows_bot;
    int cols_mid;
    int cols_end;
    int queued_at;
    bit last_col;
    bit last_row;
    w = clamp_dim(map_width, MaxWidth);
    h = clamp_dim(map_height, MaxRows);
    c = (col_cnt >= w) ? w - 1 : col_cnt;
    r = (row_cnt >= h) ? h - 1 : row_cnt;
    last_col = (c == w - 1);
    last_row = (r == h - 1);
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = upper_line[c];
    win[1][2] = middle_line[c];
    win[2][2] = sample;
    upper_line[c] = middle_line[c];
    middle_line[c] = sample;
    rows_full = (r >= 2) ? 0 : 1;
    rows_bot = (r >= 1) ? 1 : 2;
    cols_mid = (c >= 2) ? 0 : 1;
    cols_end = (c >= 1) ? 1 : 2;
    queued_at = awaited_means.size();
    if (r >= 1 && c >= 1)
      queue_mean('{window_mean(rows_full, cols_mid), OutColBits'(c - 1),
                   OutRowBits'(r - 1), 1'b0});
    if (r >= 1 && last_col)
      queue_mean('{window_mean(rows_full, cols_end), OutColBits'(c),
                   OutRowBits'(r - 1), 1'b0});
    if (last_row && c >= 1)
      queue_mean('{window_mean(rows_bot, cols_mid), OutColBits'(c - 1),
                   OutRowBits'(r), 1'b0});
    if (last_row && last_col)
      queue_mean('{window_mean(rows_bot, cols_end), OutColBits'(c),
                   OutRowBits'(r), 1'b0});
    if (awaited_means.size() > queued_at)
      awaited_means[awaited_means.size() - 1].last_of_run = 1'b1;
    if (last_col) begin
      col_cnt = 0;
      row_cnt = last_row ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
      row_cnt = r;
    end
  endtask

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PrintLimit) $display("%0t ns mismatch: %s", $realtime, msg);
  endtask

  function automatic logic signed [SampleBits-1:0] pick_height();
    case ($urandom_range(0, 7))
      0:       return {1'b0, {(SampleBits - 1){1'b1}}};
      1:       return {1'b1, {(SampleBits - 1){1'b0}}};
      2, 3:    return SampleBits'($urandom_range(0, 8) - 4);
      default: return SampleBits'($urandom());
    endcase
  endfunction

  function automatic int pick_dim();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1);
      1:       return $urandom_range(7, 12);
      default: return $urandom_range(2, 6);
    endcase
  endfunction

  // idle once nothing waits to go in or come out and the last item has drained;
  // checked again after settling as the source may pop its last item on the same edge
  task automatic wait_until_idle();
    forever begin
      while (height_stream.size() != 0 || in_if.valid || awaited_means.size() != 0)
        @(posedge clk_i);
      repeat (SettleCycles) @(posedge clk_i);
      if (height_stream.size() == 0 && !in_if.valid && awaited_means.size() == 0) break;
    end
  endtask

  task automatic write_map_reg(input cfg_reg_e which, input logic [CfgBits-1:0] value);
    wait_until_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= which;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (which == CFG_MAP_WIDTH) map_width = value;
    else map_height = value;
    // any register write restarts the frame
    col_cnt = 0;
    row_cnt = 0;
  endtask

  task automatic set_map_size(input int w, input int h);
    write_map_reg(CFG_MAP_WIDTH, CfgBits'(w));
    write_map_reg(CFG_MAP_HEIGHT, CfgBits'(h));
  endtask

  // sample source: bursts of random length, random gaps between them
  always @(posedge clk_i) begin
    logic accepted;
    logic next_valid;
    accepted = in_if.valid && in_if.ready;
    next_valid = in_if.valid && !accepted;
    if (accepted) begin
      compute_window_means(in_if.height_in);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      end
    end
    if (rst_ni && !next_valid) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (height_stream.size() != 0) begin
        next_valid = 1'b1;
        in_if.height_in <= height_stream.pop_front();
      end
    end
    in_if.valid <= next_valid;
  end

  // result sink: a ready pattern drawn at random, from always ready to long holds
  always @(posedge clk_i) begin
    if (stall_tick % 64 == 0) stall_mode = sink_mode_e'($urandom_range(0, 3));
    stall_tick++;
    case (stall_mode)
      READY_ALWAYS:      out_if.ready <= 1'b1;
      READY_COIN:        out_if.ready <= 1'($urandom_range(0, 1));
      READY_ONE_IN_FOUR: out_if.ready <= (stall_tick % 4 == 0);
      default:           out_if.ready <= (stall_tick % 16 >= 12);
    endcase
  end

  always @(posedge clk_i) begin
    filt_mean_t want;
    if (out_if.valid && out_if.ready) begin
      if (awaited_means.size() == 0) begin
        flag_mismatch($sformatf("unexpected result %0d at row %0d col %0d",
                                out_if.height_out, out_if.out_row, out_if.out_col));
      end else begin
        want = awaited_means.pop_front();
        if (out_if.height_out !== want.height_out)
          flag_mismatch($sformatf("height_out %0d, want %0d at row %0d col %0d",
                                  out_if.height_out, want.height_out, want.out_row,
                                  want.out_col));
        if (out_if.out_col !== want.out_col)
          flag_mismatch($sformatf("out_col %0d, want %0d", out_if.out_col, want.out_col));
        if (out_if.out_row !== want.out_row)
          flag_mismatch($sformatf("out_row %0d, want %0d", out_if.out_row, want.out_row));
        if (out_if.last_of_run !== want.last_of_run)
          flag_mismatch($sformatf("last_of_run %0b, want %0b at row %0d col %0d",
                                  out_if.last_of_run, want.last_of_run, want.out_row,
                                  want.out_col));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("heightmap_box_filter_3x3_top_tb: FAIL");
      $finish;
    end
  end

  initial begin
    int ramp_3x3 [9] = '{32767, 32767, 32767, -32768, -32768, -32768, 1, 2, -3};
    int ties_2x2 [8] = '{2, 0, 0, 0, -2, 0, 0, 0};
    int random_heights;
    int area;
    int n;
    int w_cfg;
    int h_cfg;

    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.height_in = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_MAP_WIDTH;
    cfg_if.data = '0;
    map_width = MapDimReset;
    map_height = MapDimReset;
    col_cnt = 0;
    row_cnt = 0;
    for (int i = 0; i < MaxWidth; i++) begin
      upper_line[i] = 0;
      middle_line[i] = 0;
    end
    for (int i = 0; i < 9; i++) win[i / 3][i % 3] = 0;
    mismatch_count = 0;
    cycle_count = 0;
    burst_left = 1;
    gap_left = 0;
    stall_tick = 0;
    stall_mode = READY_ALWAYS;
    random_heights = 0;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset size: a few samples of the first row, then cut short by the next write
    repeat (8) queue_height(pick_height());

    // corners, edges and centre, mostly on full-scale values
    set_map_size(3, 3);
    foreach (ramp_3x3[i]) queue_height(SampleBits'(ramp_3x3[i]));

    // zero size acts as one: each sample is a whole map
    set_map_size(0, 0);
    queue_height(SampleBits'(1));
    queue_height(SampleBits'(-1));
    queue_height(SampleBits'(32767));

    // halves round away from zero, both signs, across a frame wrap
    set_map_size(2, 2);
    foreach (ties_2x2[i]) queue_height(SampleBits'(ties_2x2[i]));

    // oversized width saturates rather than wrapping, one row
    set_map_size(MaxWidth + 1, 0);
    repeat (16) queue_height(pick_height());

    // oversized height saturates rather than wrapping, one column
    set_map_size(0, MaxRows + 1);
    repeat (16) queue_height(pick_height());

    // mostly whole frames of small maps, some cut short by a register write
    while (random_heights < RandomHeights) begin
      w_cfg = pick_dim();
      h_cfg = pick_dim();
      case ($urandom_range(0, 3))
        0:       write_map_reg(CFG_MAP_WIDTH, CfgBits'(w_cfg));
        1:       write_map_reg(CFG_MAP_HEIGHT, CfgBits'(h_cfg));
        default: set_map_size(w_cfg, h_cfg);
      endcase
      area = clamp_dim(map_width, MaxWidth) * clamp_dim(map_height, MaxRows);
      n = area * ((area > 40) ? 1 : $urandom_range(1, 3));
      if ($urandom_range(0, 3) == 0 && area > 1) n += $urandom_range(1, area - 1);
      if (n > RandomHeights - random_heights) n = RandomHeights - random_heights;
      repeat (n) queue_height(pick_height());
      random_heights += n;
    end

    wait_until_idle();
    if (mismatch_count == 0) $display("heightmap_box_filter_3x3_top_tb: PASS");
    else $display("heightmap_box_filter_3x3_top_tb: FAIL");
    $finish;
  end

endmodule

// ===== heightmap_box_filter_3x3_top.f =====
src/hmbf_pkg.sv
src/hmbf_if.sv
src/hmbf_ctrl.sv
src/hmbf_datapath.sv
src/heightmap_box_filter_3x3_top.sv
dv/heightmap_box_filter_3x3_top_tb.sv
